>>> hw/rtl/fmrf_pkg.sv
// Package for the flood mesh receive filter: request and response payload types,
// controller state and command/status structs, verdict and register codes.
// Depends on nothing; every other RTL file of the block but fmrf_ram uses it.
`default_nettype none

package fmrf_pkg;

   localparam int ID_WIDTH        = 32;
   localparam int TTL_WIDTH       = 8;
   localparam int FLAGS_WIDTH     = 4;
   localparam int VERDICT_WIDTH   = 2;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int KEY_WIDTH       = 2 * ID_WIDTH;

   // Verdict codes of a response.
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_ACCEPTED  = 2'd0;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_MALFORMED = 2'd1;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_OWN       = 2'd2;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_DUPLICATE = 2'd3;

   // Bit positions inside the flags field.
   localparam int FLAG_ACK_REQUEST_BIT = 0;
   localparam int FLAG_ACK_BIT         = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OWN_ID       = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BROADCAST_ID = 8'd1;

   localparam logic [ID_WIDTH-1:0] RESET_OWN_ID       = 32'h0000_0000;
   localparam logic [ID_WIDTH-1:0] RESET_BROADCAST_ID = 32'hFFFF_FFFF;

   typedef struct packed {
      logic                   frame_ok;
      logic [ID_WIDTH-1:0]    origin_id;
      logic [ID_WIDTH-1:0]    dest_id;
      logic [ID_WIDTH-1:0]    seq_num;
      logic [TTL_WIDTH-1:0]   ttl;
      logic [FLAGS_WIDTH-1:0] flags;
   } req_type;

   typedef struct packed {
      logic [VERDICT_WIDTH-1:0] verdict;
      logic                     deliver;
      logic                     send_ack;
      logic [ID_WIDTH-1:0]      ack_dest;
      logic [ID_WIDTH-1:0]      ack_seq;
      logic                     forward;
      logic [TTL_WIDTH-1:0]     forward_ttl;
      logic                     is_ack;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_INSERT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                     start;
      logic                     scan;
      logic                     insert;
      logic                     load_rsp;
      logic [VERDICT_WIDTH-1:0] verdict;
   } cmd_type;

   typedef struct packed {
      logic drop_bad;
      logic drop_own;
      logic hit;
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/flood_mesh_receive_filter_top.sv
// Top level of the flood mesh receive filter: duplicate suppression and
// delivery/ACK/forward decisions for parsed packet headers.
// Depends on fmrf_pkg, fmrf_ctrl, fmrf_datapath and fmrf_ram.
//
// Usage:
// One request on req_* carries a parsed header (req_type). It is accepted at a
// rising edge where req_valid is high and req_stall is low. Exactly one
// response (rsp_type) comes back on rsp_*, taken where rsp_valid is high and
// rsp_stall is low. Registers own_id (index 0) and broadcast_id (index 1) are
// written through csr_*, which is always ready; other indexes are ignored.
// Write them only while no request is in flight.
// A request passes a check state, then scans the filled part of the ring
// cache, one RAM read per cycle, then goes through an insert state and loads
// the response register. A header dropped in the check skips the scan and the
// insert; a hit in the scan skips the insert. The cache RAM read port is
// registered.
// One request is worked on at a time; req_stall is high while it is.
// A finished response waits in its own register, so a new request is taken
// while the receiver stalls; if the next response is ready before the old one
// is taken, the block holds it and keeps req_stall high until rsp_stall drops.
// Reset (synchronous, active high) empties the cache through a fill count at
// once, restores the register defaults and drops rsp_valid; no clearing pass.
`default_nettype none

module flood_mesh_receive_filter_top #(
   parameter int CACHE_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fmrf_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fmrf_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fmrf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fmrf_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   fmrf_pkg::cmd_type    cmd;
   fmrf_pkg::status_type status;
   logic                 idle;
   logic                 req_accept;

   // Register writes are taken as they come, so the port never pushes back.
   assign csr_ready  = 1'b1;
   assign req_stall  = !idle;
   assign req_accept = req_valid && !req_stall;

   fmrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle)
   );

   fmrf_datapath #(
      .CACHE_DEPTH (CACHE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

`ifndef SYNTHESIS
   // Once a request is taken, the block is busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request accepted but block not busy next cycle");

   // A rejected header reports nothing but its verdict.
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.verdict != fmrf_pkg::VERDICT_ACCEPTED)) |->
      (!rsp_data.deliver && !rsp_data.send_ack && !rsp_data.forward && !rsp_data.is_ack))
      else $error("rejected response carries decision bits");

   // An ACK goes only for a unicast delivered to us, which is never forwarded.
   a_ack_not_forwarded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.send_ack) |-> (rsp_data.deliver && !rsp_data.forward))
      else $error("ACK response without delivery or with forward");

   // A forwarded copy always has hops left.
   a_forward_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.forward) |-> (rsp_data.forward_ttl != '0))
      else $error("forward with zero hop count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/fmrf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module fmrf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fmrf_ctrl.sv
// Controller state machine of the flood mesh receive filter.
// Depends on fmrf_pkg; drives the datapath through cmd_type and reads status_type.
`default_nettype none

module fmrf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  fmrf_pkg::status_type  status,
   output fmrf_pkg::cmd_type     cmd,
   output logic                  idle
);

   fmrf_pkg::state_type                          state_ff, state_in;
   logic [fmrf_pkg::VERDICT_WIDTH-1:0]           verdict_ff, verdict_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fmrf_pkg::ST_IDLE;
         verdict_ff <= fmrf_pkg::VERDICT_ACCEPTED;
      end else begin
         state_ff   <= state_in;
         verdict_ff <= verdict_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      verdict_in  = verdict_ff;
      cmd         = '0;
      cmd.verdict = verdict_ff;
      idle        = 1'b0;
      case (state_ff)
         fmrf_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = fmrf_pkg::ST_CHECK;
            end
         end
         fmrf_pkg::ST_CHECK: begin
            // Malformed frames win over own packets, which win over the cache.
            if (status.drop_bad) begin
               verdict_in = fmrf_pkg::VERDICT_MALFORMED;
               state_in   = fmrf_pkg::ST_RESULT;
            end else if (status.drop_own) begin
               verdict_in = fmrf_pkg::VERDICT_OWN;
               state_in   = fmrf_pkg::ST_RESULT;
            end else begin
               state_in = fmrf_pkg::ST_SCAN;
            end
         end
         fmrf_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit) begin
               verdict_in = fmrf_pkg::VERDICT_DUPLICATE;
               state_in   = fmrf_pkg::ST_RESULT;
            end else if (status.scan_done) begin
               state_in = fmrf_pkg::ST_INSERT;
            end
         end
         fmrf_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            verdict_in = fmrf_pkg::VERDICT_ACCEPTED;
            state_in   = fmrf_pkg::ST_RESULT;
         end
         fmrf_pkg::ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = fmrf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fmrf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/fmrf_datapath.sv
// Datapath of the flood mesh receive filter: request and configuration registers,
// the ring cache with its scan counter, and the response register.
// Depends on fmrf_pkg and fmrf_ram.
`default_nettype none

module fmrf_datapath #(
   parameter int CACHE_DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fmrf_pkg::req_type                       req_data,
   input  logic                                    csr_we,
   input  logic [fmrf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [fmrf_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  logic                                    rsp_stall,
   output logic                                    rsp_valid,
   output fmrf_pkg::rsp_type                       rsp_data,
   input  fmrf_pkg::cmd_type                       cmd,
   output fmrf_pkg::status_type                    status
);

   localparam int ADDR_W = $clog2(CACHE_DEPTH);
   localparam int CNT_W  = $clog2(CACHE_DEPTH + 1);
   localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(CACHE_DEPTH);
   localparam logic [ADDR_W-1:0] HEAD_LAST = ADDR_W'(CACHE_DEPTH - 1);

   fmrf_pkg::req_type                     req_ff;
   logic [fmrf_pkg::ID_WIDTH-1:0]         own_id_ff, broadcast_id_ff;
   logic [CNT_W-1:0]                      idx_ff, idx_in;
   logic [CNT_W-1:0]                      fill_ff, fill_in;
   logic [ADDR_W-1:0]                     head_ff, head_in;
   logic                                  pending_ff, pending_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   fmrf_pkg::rsp_type                     rsp_ff, rsp_in;

   logic                                  more;
   logic                                  issue;
   logic [fmrf_pkg::KEY_WIDTH-1:0]        key;
   logic [fmrf_pkg::KEY_WIDTH-1:0]        rd_data;
   logic                                  bcast, for_us, ack, fwd;

   assign key   = {req_ff.origin_id, req_ff.seq_num};
   // Entries below the fill count have all been written, so only they are read.
   assign more  = (idx_ff < fill_ff);
   assign issue = cmd.scan && more;

   fmrf_ram #(
      .WIDTH (fmrf_pkg::KEY_WIDTH),
      .DEPTH (CACHE_DEPTH)
   ) u_cache (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (head_ff),
      .wr_data (key),
      .rd_en   (issue),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      status.drop_bad  = !req_ff.frame_ok;
      status.drop_own  = (req_ff.origin_id == own_id_ff);
      status.hit       = pending_ff && (rd_data == key);
      status.scan_done = !more && !pending_ff;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      idx_in     = idx_ff;
      pending_in = issue;
      if (cmd.start) begin
         idx_in     = '0;
         pending_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.insert) begin
         head_in = (head_ff == HEAD_LAST) ? '0 : head_ff + ADDR_W'(1);
         fill_in = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + CNT_W'(1);
      end
   end

   always_comb begin
      bcast  = (req_ff.dest_id == broadcast_id_ff);
      for_us = (req_ff.dest_id == own_id_ff) || bcast;
      ack    = for_us && !bcast && req_ff.flags[fmrf_pkg::FLAG_ACK_REQUEST_BIT];
      fwd    = (req_ff.ttl > fmrf_pkg::TTL_WIDTH'(1)) && (bcast || !for_us);

      rsp_in         = '0;
      rsp_in.verdict = cmd.verdict;
      if (cmd.verdict == fmrf_pkg::VERDICT_ACCEPTED) begin
         rsp_in.deliver     = for_us;
         rsp_in.send_ack    = ack;
         rsp_in.ack_dest    = ack ? req_ff.origin_id : '0;
         rsp_in.ack_seq     = ack ? req_ff.seq_num : '0;
         rsp_in.forward     = fwd;
         rsp_in.forward_ttl = fwd ? (req_ff.ttl - fmrf_pkg::TTL_WIDTH'(1)) : '0;
         rsp_in.is_ack      = req_ff.flags[fmrf_pkg::FLAG_ACK_BIT];
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff       <= fmrf_pkg::RESET_OWN_ID;
         broadcast_id_ff <= fmrf_pkg::RESET_BROADCAST_ID;
         idx_ff          <= '0;
         fill_ff         <= '0;
         head_ff         <= '0;
         pending_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we && (csr_index == fmrf_pkg::CSR_OWN_ID)) begin
            own_id_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == fmrf_pkg::CSR_BROADCAST_ID)) begin
            broadcast_id_ff <= csr_wdata;
         end
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
